>>> sv/sha_pkg.sv
package sha_pkg;

    typedef logic [31:0] t_word;

    // Control from the sequencer to the compression core.
    typedef struct packed {
        logic       wr;     // place one byte into the block buffer
        logic       init;   // load the initial hash values
        logic [5:0] pos;    // byte offset within the 64-byte block
        logic [7:0] data;   // byte to place
    } t_core_ctl;

    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS_M1 = 6'd55;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned ROUNDS = 64;

    function automatic t_word f_rotr(input t_word x, input int n);
        f_rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word f_bsig0(input t_word x);
        f_bsig0 = f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic t_word f_bsig1(input t_word x);
        f_bsig1 = f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic t_word f_ssig0(input t_word x);
        f_ssig0 = f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word f_ssig1(input t_word x);
        f_ssig1 = f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word f_h_init(input logic [2:0] idx);
        case (idx)
            3'd0:    f_h_init = 32'h6a09e667;
            3'd1:    f_h_init = 32'hbb67ae85;
            3'd2:    f_h_init = 32'h3c6ef372;
            3'd3:    f_h_init = 32'ha54ff53a;
            3'd4:    f_h_init = 32'h510e527f;
            3'd5:    f_h_init = 32'h9b05688c;
            3'd6:    f_h_init = 32'h1f83d9ab;
            default: f_h_init = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word f_round_k(input logic [5:0] t);
        case (t)
            6'd0:  f_round_k = 32'h428a2f98;
            6'd1:  f_round_k = 32'h71374491;
            6'd2:  f_round_k = 32'hb5c0fbcf;
            6'd3:  f_round_k = 32'he9b5dba5;
            6'd4:  f_round_k = 32'h3956c25b;
            6'd5:  f_round_k = 32'h59f111f1;
            6'd6:  f_round_k = 32'h923f82a4;
            6'd7:  f_round_k = 32'hab1c5ed5;
            6'd8:  f_round_k = 32'hd807aa98;
            6'd9:  f_round_k = 32'h12835b01;
            6'd10: f_round_k = 32'h243185be;
            6'd11: f_round_k = 32'h550c7dc3;
            6'd12: f_round_k = 32'h72be5d74;
            6'd13: f_round_k = 32'h80deb1fe;
            6'd14: f_round_k = 32'h9bdc06a7;
            6'd15: f_round_k = 32'hc19bf174;
            6'd16: f_round_k = 32'he49b69c1;
            6'd17: f_round_k = 32'hefbe4786;
            6'd18: f_round_k = 32'h0fc19dc6;
            6'd19: f_round_k = 32'h240ca1cc;
            6'd20: f_round_k = 32'h2de92c6f;
            6'd21: f_round_k = 32'h4a7484aa;
            6'd22: f_round_k = 32'h5cb0a9dc;
            6'd23: f_round_k = 32'h76f988da;
            6'd24: f_round_k = 32'h983e5152;
            6'd25: f_round_k = 32'ha831c66d;
            6'd26: f_round_k = 32'hb00327c8;
            6'd27: f_round_k = 32'hbf597fc7;
            6'd28: f_round_k = 32'hc6e00bf3;
            6'd29: f_round_k = 32'hd5a79147;
            6'd30: f_round_k = 32'h06ca6351;
            6'd31: f_round_k = 32'h14292967;
            6'd32: f_round_k = 32'h27b70a85;
            6'd33: f_round_k = 32'h2e1b2138;
            6'd34: f_round_k = 32'h4d2c6dfc;
            6'd35: f_round_k = 32'h53380d13;
            6'd36: f_round_k = 32'h650a7354;
            6'd37: f_round_k = 32'h766a0abb;
            6'd38: f_round_k = 32'h81c2c92e;
            6'd39: f_round_k = 32'h92722c85;
            6'd40: f_round_k = 32'ha2bfe8a1;
            6'd41: f_round_k = 32'ha81a664b;
            6'd42: f_round_k = 32'hc24b8b70;
            6'd43: f_round_k = 32'hc76c51a3;
            6'd44: f_round_k = 32'hd192e819;
            6'd45: f_round_k = 32'hd6990624;
            6'd46: f_round_k = 32'hf40e3585;
            6'd47: f_round_k = 32'h106aa070;
            6'd48: f_round_k = 32'h19a4c116;
            6'd49: f_round_k = 32'h1e376c08;
            6'd50: f_round_k = 32'h2748774c;
            6'd51: f_round_k = 32'h34b0bcb5;
            6'd52: f_round_k = 32'h391c0cb3;
            6'd53: f_round_k = 32'h4ed8aa4a;
            6'd54: f_round_k = 32'h5b9cca4f;
            6'd55: f_round_k = 32'h682e6ff3;
            6'd56: f_round_k = 32'h748f82ee;
            6'd57: f_round_k = 32'h78a5636f;
            6'd58: f_round_k = 32'h84c87814;
            6'd59: f_round_k = 32'h8cc70208;
            6'd60: f_round_k = 32'h90befffa;
            6'd61: f_round_k = 32'ha4506ceb;
            6'd62: f_round_k = 32'hbef9a3f7;
            default: f_round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

>>> sv/sha256_message_digest_unit.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_data_byte, i_byte_present, i_msg_last
// out      | output    | o_out_valid / i_out_ready  | o_digest_word, o_word_index, o_digest_last
//
// An item with a byte is taken while the sequencer is idle; the 64th byte of a block
// starts the compression (64 rounds of the shared round unit, one per cycle, then the
// chaining add), after which control goes back to the sequencer.
// A last item runs the padding one byte per cycle, one or two compressions, then loads
// the eight digest words through the output register.
// Reset loads the initial hash values and clears the length count; no clearing pass.
// The output register holds a word until taken; a stall stops the digest sequencer only.
module sha256_message_digest_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_msg_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COMP = 4'b0010,
        S_PAD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_state      r_after, n_after;
    logic [5:0]  r_pos, n_pos;
    logic [60:0] r_count, n_count;
    logic        r_first, n_first;
    logic        r_len, n_len;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    t_word       r_out_word, n_out_word;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last;

    t_core_ctl   core_ctl;
    t_word       core_word;
    logic        core_busy;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;

    sha_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (core_ctl),
        .i_rd_idx  (r_idx),
        .o_rd_word (core_word),
        .o_busy    (core_busy)
    );

    assign bit_len = {r_count, 3'b000};

    always_comb begin
        case (r_pos[2:0])
            3'd0:    len_byte = bit_len[63:56];
            3'd1:    len_byte = bit_len[55:48];
            3'd2:    len_byte = bit_len[47:40];
            3'd3:    len_byte = bit_len[39:32];
            3'd4:    len_byte = bit_len[31:24];
            3'd5:    len_byte = bit_len[23:16];
            3'd6:    len_byte = bit_len[15:8];
            default: len_byte = bit_len[7:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_pos       = r_pos;
        n_count     = r_count;
        n_first     = r_first;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        core_ctl    = '0;
        core_ctl.pos  = r_pos;
        core_ctl.data = i_data_byte;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_byte_present) begin
                        core_ctl.wr = 1'b1;
                        n_pos   = r_pos + 6'd1;
                        n_count = r_count + 61'd1;
                    end
                    if (i_msg_last) begin
                        n_first = 1'b1;
                        n_len   = 1'b0;
                        n_idx   = '0;
                    end
                    if (i_byte_present && r_pos == LAST_POS) begin
                        n_state = S_COMP;
                        n_after = i_msg_last ? S_PAD : S_IDLE;
                    end else if (i_msg_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                if (!core_busy) begin
                    n_state = r_after;
                end
            end
            S_PAD: begin
                core_ctl.wr   = 1'b1;
                core_ctl.data = r_first ? PAD_BYTE : (r_len ? len_byte : 8'h00);
                n_first = 1'b0;
                n_pos   = r_pos + 6'd1;
                if (r_pos == LAST_POS) begin
                    n_state = S_COMP;
                    n_after = r_len ? S_OUT : S_PAD;
                    n_len   = 1'b0;
                end else if (!r_len && r_pos == LEN_POS_M1) begin
                    // next byte starts the 64-bit length field
                    n_len = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = core_word;
                    n_out_idx   = r_idx;
                    n_out_last  = (r_idx == 3'd7);
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        // restart for the next message
                        core_ctl.init = 1'b1;
                        n_state = S_IDLE;
                        n_pos   = '0;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_len       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_first     <= n_first;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_digest_last = r_out_last;

    a_busy_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_busy |-> r_state == S_COMP)
        else $error("compression running outside the compress state");
    a_len_field_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_len) |-> r_pos[5:3] == 3'd7)
        else $error("length bytes placed outside the last eight offsets");
    a_last_is_word7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_idx == 3'd7)
        else $error("last digest word flagged early");
    a_out_enters_at_0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) == S_COMP) |-> r_idx == 3'd0)
        else $error("digest output did not start at word 0");

endmodule

>>> sv/sha_core.sv
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    input  logic [2:0]         i_rd_idx,
    output logic [31:0]        o_rd_word,
    output logic               o_busy
);
    import sha_pkg::*;

    t_word      r_w [16];   // block buffer, then the rolling schedule window
    t_word      r_s [8];    // working variables a..h
    t_word      r_chain [8];
    logic       r_busy;
    logic       r_fin;
    logic [5:0] r_round;

    t_word      n_byte_word;
    t_word      n_sched;
    t_word      n_t1;
    t_word      n_t2;
    t_word      n_ch;
    t_word      n_maj;
    logic [3:0] wr_idx;

    assign wr_idx    = i_ctl.pos[5:2];
    assign o_rd_word = r_chain[i_rd_idx];
    assign o_busy    = r_busy;

    // Merge the incoming byte into its big-endian word.
    always_comb begin
        case (i_ctl.pos[1:0])
            2'd0:    n_byte_word = {i_ctl.data, 24'h0};
            2'd1:    n_byte_word = r_w[wr_idx] | {8'h0, i_ctl.data, 16'h0};
            2'd2:    n_byte_word = r_w[wr_idx] | {16'h0, i_ctl.data, 8'h0};
            default: n_byte_word = r_w[wr_idx] | {24'h0, i_ctl.data};
        endcase
    end

    // One round of the shared round unit.
    always_comb begin
        n_sched = f_ssig1(r_w[14]) + r_w[9] + f_ssig0(r_w[1]) + r_w[0];
        n_ch    = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        n_maj   = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        n_t1    = r_s[7] + f_bsig1(r_s[4]) + n_ch + f_round_k(r_round) + r_w[0];
        n_t2    = f_bsig0(r_s[0]) + n_maj;
    end

    // Control state and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= f_h_init(3'(i));
            end
        end else begin
            if (i_ctl.init) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= f_h_init(3'(i));
                end
            end
            if (i_ctl.wr && i_ctl.pos == LAST_POS) begin
                r_busy  <= 1'b1;
                r_fin   <= 1'b0;
                r_round <= '0;
            end else if (r_busy) begin
                if (!r_fin) begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(ROUNDS - 1)) begin
                        r_fin <= 1'b1;
                    end
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_s[i];
                    end
                    r_busy <= 1'b0;
                    r_fin  <= 1'b0;
                end
            end
        end
    end

    // Buffer and working variables.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_w[wr_idx] <= n_byte_word;
            if (i_ctl.pos == LAST_POS) begin
                for (int i = 0; i < 8; i++) begin
                    r_s[i] <= r_chain[i];
                end
            end
        end else if (r_busy && !r_fin) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_sched;
            r_s[7]  <= r_s[6];
            r_s[6]  <= r_s[5];
            r_s[5]  <= r_s[4];
            r_s[4]  <= r_s[3] + n_t1;
            r_s[3]  <= r_s[2];
            r_s[2]  <= r_s[1];
            r_s[1]  <= r_s[0];
            r_s[0]  <= n_t1 + n_t2;
        end
    end

    a_round_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_round == 6'd0 || r_round == 6'(ROUNDS - 1) + 6'd1)
        else $error("round counter moved while idle");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.wr && !i_ctl.init)
        else $error("buffer or chain written during compression");
    a_fin_after_63: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fin) |-> $past(r_round) == 6'(ROUNDS - 1))
        else $error("final add not after last round");

endmodule
